/* rtl/rsm_pkg.sv */
// ----------------------------------------------------------------------------
// rsm_pkg: shared types and constants for the row softmax unit
// Controller state, command/status structs and the exp2 table.
// ----------------------------------------------------------------------------
package rsm_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EXP_RD,
    ST_EXP_MUL,
    ST_EXP_WR,
    ST_DIV_RD,
    ST_DIV_GO,
    ST_DIV_RUN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;       // store incoming word, update peak
    logic clr_row;    // clear peak, fill and total
    logic exp_wr;     // write exponent back, accumulate
    logic div_start;  // latch dividend, start divider
    logic idx_clr;    // reset sweep index
    logic idx_inc;    // advance sweep index
  } cmd_t;

  typedef struct packed {
    logic row_done;   // current word ends the row
    logic idx_last;   // sweep index at last entry
    logic div_done;
  } stat_t;

  localparam int unsigned SCORE_W = 16;
  localparam int unsigned STORE_W = 17;
  localparam int unsigned TOTAL_W = 24;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  function automatic logic [16:0] exp2_tab(input logic [4:0] i);
    case (i)
      5'd0:  exp2_tab = 17'd65536;
      5'd1:  exp2_tab = 17'd62757;
      5'd2:  exp2_tab = 17'd60097;
      5'd3:  exp2_tab = 17'd57549;
      5'd4:  exp2_tab = 17'd55109;
      5'd5:  exp2_tab = 17'd52773;
      5'd6:  exp2_tab = 17'd50536;
      5'd7:  exp2_tab = 17'd48393;
      5'd8:  exp2_tab = 17'd46341;
      5'd9:  exp2_tab = 17'd44376;
      5'd10: exp2_tab = 17'd42495;
      5'd11: exp2_tab = 17'd40693;
      5'd12: exp2_tab = 17'd38968;
      5'd13: exp2_tab = 17'd37316;
      5'd14: exp2_tab = 17'd35734;
      5'd15: exp2_tab = 17'd34219;
      5'd16: exp2_tab = 17'd32768;
      default: exp2_tab = 17'd0;
    endcase
  endfunction

endpackage

/* rtl/rsm_ram.sv */
// ----------------------------------------------------------------------------
// rsm_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module rsm_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/rsm_div.sv */
// ----------------------------------------------------------------------------
// rsm_div: restoring divider, one quotient bit per cycle
// Computes round((e << 16) / total), saturated to 16 bits.
// ----------------------------------------------------------------------------
module rsm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [16:0] dividend,   // exponent, Q1.16
  input  logic [23:0] divisor,
  output logic        done,
  output logic [15:0] quot
);
  // numerator = (e << 16) + (total >> 1), 34 bits
  localparam int unsigned NUM_W = 34;

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [24:0]      rem_r, rem_nxt;
  logic [23:0]      den_r;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [24:0]      trial;
  logic [24:0]      diff;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[23:0], num_r[NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    if (start) begin
      num_nxt  = {1'b0, dividend, 16'd0} + {11'd0, divisor[23:1]};
      rem_nxt  = '0;
      cnt_nxt  = 6'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[24]) begin
        rem_nxt = diff;
        num_nxt = {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  assign done = busy_r && (cnt_r == 6'd1);
  // quotient lives in num_r after the last shift; saturate above 16 bits
  assign quot = (|num_nxt[NUM_W-1:16]) ? 16'hFFFF : num_nxt[15:0];
endmodule

/* rtl/rsm_datapath.sv */
// ----------------------------------------------------------------------------
// rsm_datapath: row store, peak tracking, exponent unit, sum and divider
// Driven by rsm_ctrl commands; reports row end and sweep position.
// ----------------------------------------------------------------------------
module rsm_datapath #(
  parameter int unsigned ROW_MAX = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rsm_pkg::cmd_t       cmd,
  output rsm_pkg::stat_t      stat,
  input  logic signed [15:0]  in_score,
  input  logic                in_row_end,
  output logic [15:0]         quot
);
  import rsm_pkg::*;

  localparam int unsigned AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
  localparam int unsigned FW = $clog2(ROW_MAX + 1);

  logic signed [15:0] peak_r, peak_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [FW-1:0]      idx_r, idx_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [STORE_W-1:0] ram_wdata, ram_rdata;

  // exponent pipeline: ram_rdata -> n -> product register -> e
  logic [15:0]        n_val;
  logic [32:0]        prod_r;
  logic [16:0]        e_val;
  logic [3:0]         ti;
  logic [11:0]        tr;
  logic [16:0]        ta, tb;
  logic [29:0]        tmul;
  logic [16:0]        tv;
  logic [6:0]         tk;
  logic               div_done;

  always_comb begin
    peak_nxt  = peak_r;
    fill_nxt  = fill_r;
    total_nxt = total_r;
    idx_nxt   = idx_r;
    if (cmd.load) begin
      if (in_score > peak_r) peak_nxt = in_score;
      fill_nxt = fill_r + FW'(1);
    end
    if (cmd.exp_wr) total_nxt = total_r + TOTAL_W'(e_val);
    if (cmd.clr_row) begin
      peak_nxt  = 16'sh8000;
      fill_nxt  = '0;
      total_nxt = '0;
    end
    if (cmd.idx_clr) idx_nxt = '0;
    else if (cmd.idx_inc) idx_nxt = idx_r + FW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r  <= 16'sh8000;
      fill_r  <= '0;
      total_r <= '0;
      idx_r   <= '0;
    end else begin
      peak_r  <= peak_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
      idx_r   <= idx_nxt;
    end
    prod_r <= 33'(n_val) * 33'(LOG2E_Q16);
  end

  assign n_val = 16'(peak_r - signed'(ram_rdata[15:0]));

  always_comb begin
    tk   = 7'(prod_r[32:26]);
    ti   = prod_r[25:22];
    tr   = prod_r[21:10];
    ta   = exp2_tab({1'b0, ti});
    tb   = exp2_tab({1'b0, ti} + 5'd1);
    tmul = 30'(ta - tb) * 30'(tr) + 30'd2048;
    tv   = ta - 17'(tmul[29:12]);
    e_val = (tk > 7'd16) ? 17'd0 : (tv >> tk[4:0]);
  end

  assign ram_we    = cmd.load | cmd.exp_wr;
  assign ram_addr  = cmd.load ? AW'(fill_r) : AW'(idx_r);
  assign ram_wdata = cmd.load ? {1'b0, in_score} : e_val;

  rsm_ram #(.WIDTH(STORE_W), .DEPTH(1 << AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  rsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (ram_rdata),
    .divisor  (total_r),
    .done     (div_done),
    .quot     (quot)
  );

  assign stat.row_done = in_row_end || (fill_r == FW'(ROW_MAX - 1));
  assign stat.idx_last = (idx_r + FW'(1) == fill_r);
  assign stat.div_done = div_done;
endmodule

/* rtl/rsm_ctrl.sv */
// ----------------------------------------------------------------------------
// rsm_ctrl: sequencer for the load, exponent and divide passes
// Issues datapath commands and drives the channel handshakes.
// ----------------------------------------------------------------------------
module rsm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           out_stall,
  output logic           out_valid,
  output logic           out_last,
  input  rsm_pkg::stat_t stat,
  output rsm_pkg::cmd_t  cmd,
  output logic           quot_ld
);
  import rsm_pkg::*;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   in_acc;

  assign in_acc = in_valid && (state_r == ST_LOAD);

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    case (state_r)
      ST_LOAD:    if (in_acc && stat.row_done) state_nxt = ST_EXP_RD;
      ST_EXP_RD:  state_nxt = ST_EXP_MUL;     // ram read
      ST_EXP_MUL: state_nxt = ST_EXP_WR;      // multiply register
      ST_EXP_WR:  state_nxt = stat.idx_last ? ST_DIV_RD : ST_EXP_RD;
      ST_DIV_RD:  state_nxt = ST_DIV_GO;
      ST_DIV_GO:  state_nxt = ST_DIV_RUN;
      ST_DIV_RUN: if (stat.div_done) begin
        state_nxt = ST_EMIT;
        last_nxt  = stat.idx_last;
      end
      ST_EMIT:    if (!out_stall) begin
        state_nxt = last_r ? ST_LOAD : ST_DIV_RD;
      end
      default:    state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    quot_ld   = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_acc;
        cmd.idx_clr = 1'b1;
      end
      ST_EXP_RD: ;
      ST_EXP_MUL: ;
      ST_EXP_WR: begin
        cmd.exp_wr  = 1'b1;
        cmd.idx_inc = !stat.idx_last;
        cmd.idx_clr = stat.idx_last;
      end
      ST_DIV_RD: ;
      ST_DIV_GO: cmd.div_start = 1'b1;
      ST_DIV_RUN: quot_ld = stat.div_done;
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.idx_inc = !last_r;
          cmd.clr_row = last_r;
        end
      end
      default: ;
    endcase
  end

  // ram read address must lead the data: DIV_RD reads idx, DIV_GO latches data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_last = last_r;
endmodule

/* rtl/row_softmax_unit.sv */
// ----------------------------------------------------------------------------
// row_softmax_unit: softmax over one row of Q5.10 scores
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Scores load one word per cycle into a single-port row RAM while the row
// peak is tracked. Once the row ends (in_row_end or ROW_MAX words) input
// stalls; an exponent pass reads, multiplies and writes back each entry,
// then each probability is read and latched, divided into 34 quotient bits
// by a bit-serial divider, and offered until the output is not stalled.
// Input is accepted again after the last word leaves.
module row_softmax_unit #(
  parameter int unsigned ROW_MAX = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_score,
  input  logic               in_row_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_probability,
  output logic               out_last_out
);
  import rsm_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic        quot_ld;
  logic [15:0] quot;
  logic [15:0] prob_r;

  rsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_last  (out_last_out),
    .stat      (stat),
    .cmd       (cmd),
    .quot_ld   (quot_ld)
  );

  rsm_datapath #(.ROW_MAX(ROW_MAX)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_score   (in_score),
    .in_row_end (in_row_end),
    .quot       (quot)
  );

  always_ff @(posedge clk) begin
    if (quot_ld) begin
      prob_r <= quot;
    end
  end

  assign out_probability = prob_r;
endmodule

/* rtl/row_softmax_unit_chk.sv */
// ----------------------------------------------------------------------------
// row_softmax_unit_chk: port-level checks for the row softmax unit
// Handshake stability and input/output exclusivity.
// ----------------------------------------------------------------------------
module row_softmax_unit_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_probability,
  input logic        out_last_out
);
  // results only go out while input is held off
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open during output");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_probability))
    else $error("stalled word changed");

  // after the last word the block opens for a new row
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_out |=> !in_stall)
    else $error("input not reopened after row");
endmodule

bind row_softmax_unit row_softmax_unit_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_probability (out_probability),
  .out_last_out    (out_last_out)
);

/* tb/row_softmax_unit_test.sv */
// ----------------------------------------------------------------------------
// row_softmax_unit_test: self-checking bench for the row softmax unit
// Sends rows of Q5.10 scores, predicts each row's Q0.16 probabilities and
// checks every output word in order, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module row_softmax_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROW_MAX = 64;
  localparam int unsigned WATCHDOG = 20000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_score;
  logic               in_row_end;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        out_probability;
  logic               out_last_out;

  row_softmax_unit #(.ROW_MAX(ROW_MAX)) dut (.*);

  typedef struct {
    logic [15:0] prob;
    logic        last;
  } prob_word_t;

  // predictor state for the row being loaded
  logic signed [15:0] row_scores[$];
  logic signed [15:0] row_max;
  prob_word_t         prob_queue[$];

  int unsigned err_count;
  int unsigned idle_cycles;
  int unsigned out_wait;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [16:0] exp2_frac(input int unsigned i);
    logic [16:0] t[17] = '{17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109,
                           17'd52773, 17'd50536, 17'd48393, 17'd46341, 17'd44376,
                           17'd42495, 17'd40693, 17'd38968, 17'd37316, 17'd35734,
                           17'd34219, 17'd32768};
    return t[i];
  endfunction

  // exp(-gap/1024) in Q1.16
  function automatic logic [16:0] neg_exp(input logic [15:0] gap);
    logic [63:0] t;
    logic [63:0] k;
    logic [15:0] f;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] v;
    t = 64'(gap) * 64'd94548;
    k = t >> 26;
    f = t[25:10];
    a = 32'(exp2_frac(f[15:12]));
    b = 32'(exp2_frac(int'(f[15:12]) + 1));
    v = a - (((a - b) * 32'(f[11:0]) + 32'd2048) >> 12);
    if (k > 16) return 17'd0;
    return 17'(v >> k);
  endfunction

  task automatic close_row();
    logic [16:0] e[$];
    logic [23:0] total;
    logic [63:0] p;
    prob_word_t  w;
    total = '0;
    foreach (row_scores[j]) begin
      e.push_back(neg_exp(16'(32'(row_max) - 32'(row_scores[j]))));
      total = total + 24'(e[j]);
    end
    foreach (e[j]) begin
      p = 64'd0;
      if (total != 0) begin
        p = ((64'(e[j]) << 16) + 64'(total >> 1)) / 64'(total);
        if (p > 64'd65535) p = 64'd65535;
      end
      w.prob = p[15:0];
      w.last = (j == e.size() - 1);
      prob_queue.push_back(w);
    end
    row_scores.delete();
    row_max = -16'sd32768;
  endtask

  task automatic predict_score(input logic signed [15:0] s, input logic end_flag);
    row_scores.push_back(s);
    if (s > row_max) row_max = s;
    if (end_flag || row_scores.size() == ROW_MAX) close_row();
  endtask

  task automatic report(input string what);
    err_count++;
    $display("ERROR %0t: %s", $realtime, what);
  endtask

  task automatic send_score(input logic signed [15:0] s, input logic end_flag);
    int unsigned gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      @(posedge clk);
      in_valid <= 1'b0;
    end
    @(posedge clk);
    in_valid   <= 1'b1;
    in_score   <= s;
    in_row_end <= end_flag;
    do @(posedge clk); while (in_stall);
    predict_score(s, end_flag);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (prob_queue.size() != 0) @(posedge clk);
  endtask

  task automatic send_row(input int unsigned len, input int unsigned spread);
    logic signed [15:0] base;
    base = 16'($urandom);
    for (int unsigned j = 0; j < len; j++) begin
      if (spread == 0) send_score(16'($urandom), j == len - 1);
      else send_score(16'(32'(base) + $urandom_range(0, spread) - spread / 2),
                      j == len - 1);
    end
  endtask

  task automatic test_directed();
    send_score(16'sd100, 1'b1);                 // single entry: 1.0 saturates
    send_score(16'sd32767, 1'b0);
    send_score(-16'sd32768, 1'b1);              // widest gap
    send_score(16'sd0, 1'b0);
    send_score(16'sd0, 1'b0);
    send_score(16'sd0, 1'b1);                   // equal scores
    send_score(-16'sd5, 1'b0);
    send_score(16'sd1024, 1'b0);
    send_score(16'sd2048, 1'b0);
    send_score(-16'sd1, 1'b1);
    send_score(16'sh5555, 1'b0);
    send_score(16'shAAAA, 1'b1);
  endtask

  task automatic test_full_row();
    // a full row closes on its own, no row_end anywhere
    for (int unsigned j = 0; j < ROW_MAX; j++)
      send_score(16'($urandom), 1'b0);
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < 40) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, ROW_MAX)
                                        : $urandom_range(1, 8);
      send_row(len, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8000));
      sent += len;
      if ($urandom_range(0, 7) == 0) drain();
    end
  endtask

  // result side: random stalls for each word, compare against oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (prob_queue.size() == 0) begin
          report($sformatf("unexpected word prob=%0d", out_probability));
        end else begin
          prob_word_t w;
          w = prob_queue.pop_front();
          if (out_probability !== w.prob)
            report($sformatf("probability %0d, expected %0d", out_probability, w.prob));
          if (out_last_out !== w.last)
            report($sformatf("last_out %b, expected %b", out_last_out, w.last));
        end
        out_wait = $urandom_range(0, 6);
      end else if (out_valid && out_wait != 0) begin
        out_wait = out_wait - 1;
      end
      out_stall <= (out_wait != 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("** row_softmax_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_score   = '0;
    in_row_end = 1'b0;
    out_stall  = 1'b0;
    out_wait   = 0;
    err_count  = 0;
    idle_cycles = 0;
    row_max    = -16'sd32768;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_row();
    drain();
    test_random();
    send_score(16'sd7, 1'b1);
    drain();
    repeat (100) @(posedge clk);
    if (err_count == 0 && prob_queue.size() == 0) begin
      $display("** row_softmax_unit: PASSED **");
    end else begin
      $display("** row_softmax_unit: FAILED **");
    end
    $finish;
  end
endmodule
